// ===== rtl/sbavg_pkg.sv =====
// ----------------------------------------------------------------------------
// Spectrum background average package
// Shared widths, codes, types and the sequencer states of the averager.
// ----------------------------------------------------------------------------
package sbavg_pkg;

    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 1;
    localparam int POWER_W          = 32;
    localparam int DIFF_W           = POWER_W + 1;
    localparam int ACC_W            = DIFF_W + WEIGHT_W + 1;
    localparam int COUNT_W          = 16;
    localparam int BINCNT_W         = 11;
    localparam int IDX_W            = 10;
    localparam int CFG_ADDR_W       = 2;
    localparam int CFG_DATA_W       = 17;
    localparam int IN_DATA_W        = 32;
    localparam int IN_USER_W        = 2;
    localparam int OUT_DATA_W       = 64;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
    localparam logic [WEIGHT_W-1:0] ALPHA_RESET  = 17'd655;
    localparam logic [COUNT_W-1:0]  RUNIN_RESET  = 16'd100;
    localparam logic [BINCNT_W-1:0] BINCNT_RESET = 11'd1024;

    localparam int USER_FUNC  = 0;
    localparam int USER_VALID = 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ALPHA     = 2'd0,
        REG_RUNIN     = 2'd1,
        REG_SLICE_LEN = 2'd2
    } sbavg_reg_t;

    typedef enum logic {
        MODE_DIV,
        MODE_MUL
    } sbavg_mode_t;

    typedef struct packed {
        logic        start;
        sbavg_mode_t mode;
    } sbavg_unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sbavg_unit_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_MUL_START,
        ST_MUL,
        ST_OUT
    } sbavg_state_t;

endpackage

// ===== rtl/sbavg_store.sv =====
// ----------------------------------------------------------------------------
// Background store
// One-write, one-read memory of per-bin backgrounds with registered read data.
// ----------------------------------------------------------------------------
module sbavg_store
    import sbavg_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [POWER_W-1:0] wdata,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [POWER_W-1:0] rdata
);

    logic [POWER_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sbavg_unit.sv =====
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// One add/subtract stage reused bit by bit: a restoring divide of the weight
// numerator by the slice count, or a shift-add multiply of weight and power
// difference followed by the add of the scaled old background.
// ----------------------------------------------------------------------------
module sbavg_unit
    import sbavg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  sbavg_unit_cmd_t           cmd,
    input  logic [COUNT_W-1:0]        divisor,
    input  logic signed [DIFF_W-1:0]  diff,
    input  logic [WEIGHT_W-1:0]       weight,
    input  logic [POWER_W-1:0]        base,
    output sbavg_unit_stat_t          stat,
    output logic [WEIGHT_W-1:0]       quotient,
    output logic [POWER_W-1:0]        result
);

    localparam int DIV_STEPS = WEIGHT_W;
    localparam int MUL_STEPS = WEIGHT_W + 1;
    localparam int STEP_W    = $clog2(MUL_STEPS);

    logic                      busy_reg;
    logic                      done_reg;
    sbavg_mode_t               mode_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [COUNT_W-1:0]        rem_reg;
    logic [WEIGHT_W-1:0]       quo_reg;
    logic [WEIGHT_W-1:0]       w_reg;
    logic signed [DIFF_W-1:0]  d_reg;
    logic [COUNT_W-1:0]        dvs_reg;
    logic [POWER_W-1:0]        base_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    logic                      div_bit;
    logic [COUNT_W:0]          rem_sh;
    logic                      add_sub;
    logic signed [ACC_W-1:0]   add_a;
    logic signed [ACC_W-1:0]   add_b;
    logic signed [ACC_W-1:0]   alu_sum;

    // The numerator is a single one at the top, so only the first step shifts it in.
    assign div_bit = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign rem_sh  = {rem_reg, div_bit};

    always_comb
    begin
        add_sub = 1'b0;
        add_a   = '0;
        add_b   = '0;
        if (mode_reg == MODE_DIV)
        begin
            add_sub = 1'b1;
            add_a   = {{(ACC_W - COUNT_W - 1){1'b0}}, rem_sh};
            add_b   = {{(ACC_W - COUNT_W){1'b0}}, dvs_reg};
        end
        else if (step_reg != '0)
        begin
            add_a = acc_reg <<< 1;
            add_b = w_reg[WEIGHT_W-1] ? {{(ACC_W - DIFF_W){d_reg[DIFF_W-1]}}, d_reg} : '0;
        end
        else
        begin
            add_a = acc_reg;
            add_b = {{(ACC_W - POWER_W - WEIGHT_FRAC_BITS){1'b0}}, base_reg,
                     {WEIGHT_FRAC_BITS{1'b0}}};
        end
    end

    assign alu_sum = add_sub ? (add_a - add_b) : (add_a + add_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= MODE_MUL;
            step_reg <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            mode_reg <= cmd.mode;
            step_reg <= (cmd.mode == MODE_DIV) ? STEP_W'(DIV_STEPS - 1)
                                               : STEP_W'(MUL_STEPS - 1);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dvs_reg  <= divisor;
            d_reg    <= diff;
            w_reg    <= weight;
            base_reg <= base;
            acc_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (mode_reg == MODE_DIV)
            begin
                rem_reg <= alu_sum[ACC_W-1] ? rem_sh[COUNT_W-1:0] : alu_sum[COUNT_W-1:0];
                quo_reg <= {quo_reg[WEIGHT_W-2:0], ~alu_sum[ACC_W-1]};
            end
            else
            begin
                acc_reg <= alu_sum;
                w_reg   <= w_reg << 1;
            end
        end
    end

    assign stat     = '{busy: busy_reg, done: done_reg};
    assign quotient = quo_reg;
    assign result   = acc_reg[WEIGHT_FRAC_BITS +: POWER_W];

endmodule

// ===== rtl/spectrum_background_average.sv =====
// ----------------------------------------------------------------------------
// Spectrum background average
// Per-bin exponential moving average of spectrum power with a cumulative-mean
// run-in over the first slices.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata: power; tuser: func, power_valid
//  m_axis    out        tdata: background, bin_index, slices_done; tlast: last_bin
//  cfg       in         write of alpha, runin_count or slice length
//
//  A valid bin is read and then runs the 18 steps of the shared multiply
//  unit; the first bin of a run-in slice runs a division in the same unit
//  first. An invalid bin skips the unit, and a clear request goes straight
//  to the output state. After reset and after each clear request a sweep
//  over all BINS entries zeroes the store, and no request is taken during it.
//  A finished result waits in the output register; the block takes the next
//  request meanwhile and stalls only when a second result is ready.
// ----------------------------------------------------------------------------
module spectrum_background_average
    import sbavg_pkg::*;
#(
    parameter int BINS = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] power
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [0] func, [1] power_valid
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] background, [41:32] bin_index,
                                                  // [57:42] slices_done, [63:58] zero
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ADDR_W = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int CMP_W  = (ADDR_W + 1 > BINCNT_W) ? ADDR_W + 1 : BINCNT_W;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(BINS - 1);
    localparam logic [CMP_W-1:0]  BINS_MAX = CMP_W'(BINS);

    sbavg_state_t          state_reg;
    sbavg_state_t          state_next;

    logic [WEIGHT_W-1:0]   alpha_reg;
    logic [COUNT_W-1:0]    runin_reg;
    logic [BINCNT_W-1:0]   slice_len_reg;

    logic [COUNT_W-1:0]    cnt_reg;
    logic [ADDR_W-1:0]     pos_reg;
    logic [WEIGHT_W-1:0]   weight_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic                  clr_reg;
    logic                  m_valid_reg;

    logic [POWER_W-1:0]    power_reg;
    logic                  pvalid_reg;
    logic [POWER_W-1:0]    bg_reg;
    logic [POWER_W-1:0]    res_reg;
    logic [POWER_W-1:0]    out_bg_reg;
    logic [IDX_W-1:0]      out_idx_reg;
    logic                  out_last_reg;
    logic [COUNT_W-1:0]    out_cnt_reg;

    logic                  in_req;
    logic                  out_load;
    logic [COUNT_W-1:0]    cnt_inc;
    logic                  runin_div;
    logic [WEIGHT_W-1:0]   alpha_sat;
    logic [WEIGHT_W-1:0]   quo_sat;
    logic [CMP_W-1:0]      bc_ext;
    logic [CMP_W-1:0]      bins_eff;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      pos_inc;
    logic                  last;

    sbavg_unit_cmd_t       unit_cmd;
    sbavg_unit_stat_t      unit_stat;
    logic [WEIGHT_W-1:0]   unit_quo;
    logic [POWER_W-1:0]    unit_result;
    logic signed [DIFF_W-1:0] unit_diff;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [POWER_W-1:0]    mem_wdata;
    logic [POWER_W-1:0]    mem_rdata;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_req        = s_axis_tvalid && s_axis_tready;

    assign cnt_inc   = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign runin_div = (pos_reg == '0) && (cnt_inc < runin_reg);
    assign alpha_sat = (alpha_reg > WEIGHT_ONE) ? WEIGHT_ONE : alpha_reg;
    assign quo_sat   = (unit_quo > WEIGHT_ONE) ? WEIGHT_ONE : unit_quo;

    assign bc_ext   = CMP_W'(slice_len_reg);
    assign bins_eff = (bc_ext == '0) ? CMP_W'(1) : ((bc_ext > BINS_MAX) ? BINS_MAX : bc_ext);
    assign pos_ext  = CMP_W'(pos_reg);
    assign pos_inc  = pos_ext + CMP_W'(1);
    assign last     = (pos_inc >= bins_eff);

    assign unit_diff = signed'({1'b0, power_reg}) - signed'({1'b0, bg_reg});

    sbavg_unit u_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (unit_cmd),
        .divisor  (cnt_inc),
        .diff     (unit_diff),
        .weight   (weight_reg),
        .base     (bg_reg),
        .stat     (unit_stat),
        .quotient (unit_quo),
        .result   (unit_result)
    );

    sbavg_store #(
        .DEPTH  (BINS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (pos_reg),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unit_cmd   = '{start: 1'b0, mode: MODE_MUL};
        mem_we     = 1'b0;
        mem_waddr  = pos_reg;
        mem_wdata  = unit_result;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_req)
                begin
                    state_next = s_axis_tuser[USER_FUNC] ? ST_OUT : ST_READ;
                end
            end
            ST_READ:
            begin
                if (runin_div)
                begin
                    unit_cmd   = '{start: 1'b1, mode: MODE_DIV};
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_MUL_START;
                end
            end
            ST_DIV:
            begin
                if (unit_stat.done)
                begin
                    state_next = ST_MUL_START;
                end
            end
            ST_MUL_START:
            begin
                if (pvalid_reg)
                begin
                    unit_cmd   = '{start: 1'b1, mode: MODE_MUL};
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL:
            begin
                if (unit_stat.done)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = clr_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= ALPHA_RESET;
            runin_reg     <= RUNIN_RESET;
            slice_len_reg <= BINCNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ALPHA:     alpha_reg     <= cfg_wdata;
                REG_RUNIN:     runin_reg     <= cfg_wdata[COUNT_W-1:0];
                REG_SLICE_LEN: slice_len_reg <= cfg_wdata[BINCNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            pos_reg      <= '0;
            weight_reg   <= '0;
            clr_addr_reg <= '0;
            clr_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_req)
            begin
                clr_reg <= s_axis_tuser[USER_FUNC];
                if (s_axis_tuser[USER_FUNC])
                begin
                    cnt_reg    <= '0;
                    pos_reg    <= '0;
                    weight_reg <= '0;
                end
            end
            if (state_reg == ST_READ && pos_reg == '0)
            begin
                cnt_reg <= cnt_inc;
                if (!runin_div)
                begin
                    weight_reg <= alpha_sat;
                end
            end
            if (state_reg == ST_DIV && unit_stat.done)
            begin
                weight_reg <= quo_sat;
            end
            if (out_load && !clr_reg)
            begin
                pos_reg <= last ? '0 : pos_inc[ADDR_W-1:0];
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= (clr_addr_reg == CLR_LAST) ? '0 : clr_addr_reg + 1'b1;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            power_reg  <= s_axis_tdata[POWER_W-1:0];
            pvalid_reg <= s_axis_tuser[USER_VALID];
        end
        if (state_reg == ST_READ)
        begin
            bg_reg <= mem_rdata;
        end
        if (in_req && s_axis_tuser[USER_FUNC])
        begin
            res_reg <= '0;
        end
        else if (state_reg == ST_MUL_START && !pvalid_reg)
        begin
            res_reg <= bg_reg;
        end
        else if (state_reg == ST_MUL && unit_stat.done)
        begin
            res_reg <= unit_result;
        end
        if (out_load)
        begin
            out_bg_reg   <= res_reg;
            out_idx_reg  <= pos_ext[IDX_W-1:0];
            out_last_reg <= !clr_reg && last;
            out_cnt_reg  <= cnt_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - POWER_W - IDX_W - COUNT_W){1'b0}},
                            out_cnt_reg, out_idx_reg, out_bg_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        unit_stat.busy |-> (state_reg == ST_DIV || state_reg == ST_MUL))
        else $error("Arithmetic unit busy outside a waiting state.");

    assert property (@(posedge clk) disable iff (!rst_n)
        weight_reg <= WEIGHT_ONE)
        else $error("Slice weight above one.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_req |=> state_reg != ST_IDLE)
        else $error("Accepted request left the sequencer idle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        pos_ext < BINS_MAX)
        else $error("Bin position beyond the store.");

endmodule

// ===== tb/sv/tb_spectrum_background_average.sv =====
// ----------------------------------------------------------------------------
// Spectrum background average testbench
// Drives bin power requests into the averager and checks every result,
// field by field, against a per-bin moving average computed here. It covers
// register extremes, clears, register writes in the middle of a slice, a long
// output stall and random traffic.
// ----------------------------------------------------------------------------
module tb_spectrum_background_average;

    import sbavg_pkg::*;

    localparam int NUM_BINS       = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 1440;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 30;
    localparam int END_CYCLES     = 60;
    localparam logic [63:0] UNITY_WEIGHT = 64'd1 << WEIGHT_FRAC_BITS;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef struct packed {
        logic [POWER_W-1:0] background;
        logic [IDX_W-1:0]   bin_index;
        logic               last_bin;
        logic [COUNT_W-1:0] slices_done;
    } bin_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic [POWER_W-1:0]  bg_store [NUM_BINS];
    logic [COUNT_W-1:0]  slice_cnt;
    logic [IDX_W-1:0]    bin_pos;
    logic [WEIGHT_W-1:0] slice_w;
    logic [WEIGHT_W-1:0] alpha_q;
    logic [COUNT_W-1:0]  runin_q;
    logic [BINCNT_W-1:0] bins_q;

    bin_result_t expected_bins [$];
    int          mismatches;
    int          idle_cycles;
    int          rx_hold_cycles;
    bit          tx_fast;
    bit          rx_fast;

    spectrum_background_average #(
        .BINS (NUM_BINS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_background();
        foreach (bg_store[i])
            bg_store[i] = '0;
        slice_cnt = '0;
        bin_pos   = '0;
        slice_w   = '0;
    endfunction

    function automatic bin_result_t update_background(input logic func,
                                                      input logic [POWER_W-1:0] power,
                                                      input logic valid);
        bin_result_t r;
        int unsigned nbins;
        int unsigned pos;
        logic [63:0] w;
        logic [63:0] bg;
        r = '0;
        if (func == FUNC_CLEAR)
        begin
            clear_background();
            return r;
        end
        nbins = (bins_q == '0) ? 1 : ((int'(bins_q) > NUM_BINS) ? NUM_BINS : int'(bins_q));
        pos   = int'(bin_pos) % NUM_BINS;
        if (pos == 0)
        begin
            if (slice_cnt != COUNT_MAX)
                slice_cnt = slice_cnt + 1'b1;
            if (slice_cnt < runin_q)
                w = UNITY_WEIGHT / 64'(slice_cnt);
            else
                w = 64'(alpha_q);
            if (w > UNITY_WEIGHT)
                w = UNITY_WEIGHT;
            slice_w = w[WEIGHT_W-1:0];
        end
        bg = 64'(bg_store[pos]);
        if (valid)
        begin
            w  = 64'(slice_w);
            bg = (bg * (UNITY_WEIGHT - w) + w * 64'(power)) >> WEIGHT_FRAC_BITS;
            bg_store[pos] = bg[POWER_W-1:0];
        end
        r.background  = bg[POWER_W-1:0];
        r.bin_index   = pos[IDX_W-1:0];
        r.last_bin    = (pos + 1) >= nbins;
        r.slices_done = slice_cnt;
        bin_pos = r.last_bin ? '0 : pos[IDX_W-1:0] + 1'b1;
        return r;
    endfunction

    function automatic logic [POWER_W-1:0] random_power();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic func, input logic [POWER_W-1:0] power,
                                input logic valid);
        int gap;
        logic [IN_USER_W-1:0] tuser_bits;
        gap = tx_fast ? 0 : $urandom_range(0, 12);
        tuser_bits             = '0;
        tuser_bits[USER_FUNC]  = func;
        tuser_bits[USER_VALID] = valid;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= power;
        s_axis_tuser  <= tuser_bits;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_bins.push_back(update_background(func, power, valid));
        if ($urandom_range(0, 39) == 0)
            tx_fast = !tx_fast;
    endtask

    task automatic send_sample(input logic [POWER_W-1:0] power, input logic valid);
        send_request(FUNC_SAMPLE, power, valid);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input sbavg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ALPHA:     alpha_q = value[WEIGHT_W-1:0];
            REG_RUNIN:     runin_q = value[COUNT_W-1:0];
            REG_SLICE_LEN: bins_q  = value[BINCNT_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic check_bin_result(input bin_result_t got);
        bin_result_t want;
        if (expected_bins.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result: bg=%h idx=%0d last=%b slices=%0d",
                         got.background, got.bin_index, got.last_bin, got.slices_done);
            return;
        end
        want = expected_bins.pop_front();
        if (got.background !== want.background || got.bin_index !== want.bin_index
            || got.last_bin !== want.last_bin || got.slices_done !== want.slices_done)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("Mismatch: expected bg=%h idx=%0d last=%b slices=%0d",
                         want.background, want.bin_index, want.last_bin, want.slices_done);
                $display("          actual   bg=%h idx=%0d last=%b slices=%0d",
                         got.background, got.bin_index, got.last_bin, got.slices_done);
            end
        end
    endtask

    initial
    begin
        int gap;
        bin_result_t got;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
                gap = rx_fast ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            got.background  = m_axis_tdata[31:0];
            got.bin_index   = m_axis_tdata[41:32];
            got.slices_done = m_axis_tdata[57:42];
            got.last_bin    = m_axis_tlast;
            check_bin_result(got);
            if ($urandom_range(0, 39) == 0)
                rx_fast = !rx_fast;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_default_settings();
        send_sample('1, 1'b1);
        send_sample('0, 1'b1);
        send_sample(random_power(), 1'b0);
        send_sample(32'h0001_8000, 1'b1);
    endtask

    task automatic test_weight_extremes();
        write_reg(REG_SLICE_LEN, 17'd0);
        write_reg(REG_RUNIN, 17'd65535);
        write_reg(REG_ALPHA, 17'd0);
        send_sample('1, 1'b1);
        send_sample('0, 1'b1);
        send_sample('1, 1'b1);
        write_reg(REG_RUNIN, 17'd0);
        write_reg(REG_ALPHA, 17'd65536);
        send_sample(32'h1234_5678, 1'b1);
        write_reg(REG_ALPHA, 17'd131071);
        send_sample('0, 1'b1);
        write_reg(REG_ALPHA, 17'd0);
        send_sample('1, 1'b1);
        write_reg(REG_SLICE_LEN, 17'd2047);
        write_reg(REG_ALPHA, 17'd40000);
        send_sample('1, 1'b1);
        send_sample(32'h0000_ffff, 1'b1);
    endtask

    task automatic test_clear();
        send_sample(random_power(), 1'b1);
        send_sample(random_power(), 1'b1);
        send_request(FUNC_CLEAR, random_power(), 1'b1);
        send_sample(random_power(), 1'b1);
        send_sample(random_power(), 1'b0);
    endtask

    task automatic test_mid_slice_writes();
        write_reg(REG_SLICE_LEN, 17'd8);
        write_reg(REG_RUNIN, 17'd0);
        write_reg(REG_ALPHA, 17'd30000);
        repeat (5) send_sample(random_power(), 1'b1);
        write_reg(REG_SLICE_LEN, 17'd3);
        write_reg(REG_ALPHA, 17'd100);
        repeat (3) send_sample(random_power(), 1'b1);
    endtask

    task automatic test_output_stall();
        write_reg(REG_SLICE_LEN, 17'd4);
        write_reg(REG_RUNIN, 17'd6);
        tx_fast = 1'b1;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (30) send_sample(random_power(), $urandom_range(0, 7) != 0);
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase_len;
        int pick;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: write_reg(REG_SLICE_LEN, CFG_DATA_W'($urandom_range(1, 4)));
                1: write_reg(REG_SLICE_LEN, CFG_DATA_W'($urandom_range(5, 16)));
                2: write_reg(REG_SLICE_LEN, CFG_DATA_W'($urandom_range(17, 40)));
                default:
                    case ($urandom_range(0, 3))
                        0:       write_reg(REG_SLICE_LEN, 17'd0);
                        1:       write_reg(REG_SLICE_LEN, 17'd1);
                        2:       write_reg(REG_SLICE_LEN, 17'd1024);
                        default: write_reg(REG_SLICE_LEN, 17'd2047);
                    endcase
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(REG_ALPHA, 17'd0);
                1:       write_reg(REG_ALPHA, 17'd65536);
                2:       write_reg(REG_ALPHA, CFG_DATA_W'($urandom_range(65537, 131071)));
                default: write_reg(REG_ALPHA, CFG_DATA_W'($urandom_range(0, 65535)));
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(REG_RUNIN, 17'd0);
                1:       write_reg(REG_RUNIN, 17'd65535);
                default: write_reg(REG_RUNIN, CFG_DATA_W'($urandom_range(1, 24)));
            endcase
            phase_len = $urandom_range(40, 160);
            repeat (phase_len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    send_request(FUNC_CLEAR, random_power(), 1'($urandom_range(0, 1)));
                else
                    send_sample(random_power(), pick >= 12);
                sent++;
            end
        end
    endtask

    initial
    begin
        mismatches     = 0;
        idle_cycles    = 0;
        rx_hold_cycles = 0;
        tx_fast        = 1'b0;
        rx_fast        = 1'b0;
        alpha_q        = ALPHA_RESET;
        runin_q        = RUNIN_RESET;
        bins_q         = BINCNT_RESET;
        clear_background();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= REG_ALPHA;
        cfg_wdata     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_default_settings();
        test_weight_extremes();
        test_clear();
        test_mid_slice_writes();
        test_output_stall();
        test_random_traffic();

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_bins.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== spectrum_background_average.f =====
rtl/sbavg_pkg.sv
rtl/sbavg_store.sv
rtl/sbavg_unit.sv
rtl/spectrum_background_average.sv
tb/sv/tb_spectrum_background_average.sv
